[design/zsn_pkg.sv]
// shared types and constants of the feature z-score normalizer
// no dependencies
package zsn_pkg;

  localparam int unsigned FEAT_W   = 16;
  localparam int unsigned NUM_DIMS = 4;
  localparam int unsigned Z_W      = 16;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned DIM_W    = 2;
  localparam int unsigned BIT_W    = 4;

  // one classified sample travelling from the front to the back
  typedef struct packed {
    logic [NUM_DIMS-1:0][FEAT_W-1:0] feat;
    logic                            last;
    logic                            keep;
  } zsn_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEVINIT,
    ST_DEV,
    ST_DEVFIN,
    ST_READ,
    ST_NUM,
    ST_ZRUN,
    ST_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    ZS_IDLE,
    ZS_PREP,
    ZS_STEP,
    ZS_CHECK
  } zdiv_state_e;

endpackage

[design/zsn_front.sv]
// front end: accepts samples, decides store or drop, locks until the set is out
// depends on zsn_pkg
module zsn_front #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [zsn_pkg::NUM_DIMS-1:0][zsn_pkg::FEAT_W-1:0] feat_i,
  input  logic                            is_last_i,
  input  logic                            fifo_full_i,
  input  logic                            set_done_i,
  output logic                            push_o,
  output zsn_pkg::zsn_item_t              item_o
);
  import zsn_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          lock_q, lock_d;
  logic          accept;
  logic          keep;

  assign busy_o = lock_q | fifo_full_i;
  assign accept = start_i & ~busy_o;
  assign keep   = cnt_q < CW'(MAX_SAMPLES);

  // classify the incoming sample
  always_comb begin
    item_o.feat = feat_i;
    item_o.last = is_last_i;
    item_o.keep = keep;
  end
  assign push_o = accept;

  // stored-sample count and set lock
  always_comb begin
    cnt_d  = cnt_q;
    lock_d = lock_q;
    if (set_done_i) begin
      lock_d = 1'b0;
    end
    if (accept) begin
      if (is_last_i) begin
        cnt_d  = '0;
        lock_d = 1'b1;
      end else if (keep) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lock_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      lock_q <= lock_d;
    end
  end

endmodule

[design/zsn_fifo.sv]
// short queue between front and back
// depends on zsn_pkg
module zsn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  zsn_pkg::zsn_item_t item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output logic               full_o,
  output zsn_pkg::zsn_item_t item_o
);
  import zsn_pkg::*;

  zsn_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
    end
  end

endmodule

[design/zsn_zdiv.sv]
// z-score unit: round(num * 4096 / sqrt(dev)), ties away from zero, saturated
// bit-serial search with incremental squares; depends on zsn_pkg
module zsn_zdiv #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [$clog2(MAX_SAMPLES+1)+16:0] num_i,
  input  logic [2*$clog2(MAX_SAMPLES+1)+29:0]   dev_i,
  output logic                                  done_o,
  output logic [zsn_pkg::Z_W-1:0]               z_o
);
  import zsn_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int NW = 17 + CW;
  localparam int MW = 16 + CW;
  localparam int DW = 30 + 2 * CW;
  localparam int EW = DW + 36;

  zdiv_state_e          state_q, state_d;
  logic                 neg_q;
  logic [MW-1:0]        mag_q;
  logic [DW-1:0]        dv_q;
  logic signed [EW-1:0] t_q, p_q, r_q, pc_q, rc_q;
  logic [Z_W-1:0]       lo_q, lo_n;
  logic [BIT_W-1:0]     b_q;
  logic                 done_q;
  logic [Z_W-1:0]       z_q, z_n;
  logic signed [EW-1:0] dv_ext;
  logic [2*MW-1:0]      mag_sq;
  logic                 fits;

  assign dv_ext = EW'(dv_q);
  assign mag_sq = mag_q * mag_q;
  assign fits   = pc_q <= t_q;

  // candidate with the current bit set
  always_comb begin
    lo_n = lo_q;
    if (fits) lo_n[b_q] = 1'b1;
  end

  // sign and saturation of the final magnitude
  always_comb begin
    if (!neg_q) begin
      z_n = lo_n[Z_W-1] ? Z_W'(16'h7fff) : lo_n;
    end else if (lo_n[Z_W-1]) begin
      z_n = Z_W'(16'h8000);
    end else begin
      z_n = Z_W'(-lo_n);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ZS_IDLE:  if (start_i) state_d = ZS_PREP;
      ZS_PREP:  state_d = ZS_STEP;
      ZS_STEP:  state_d = ZS_CHECK;
      ZS_CHECK: state_d = (b_q == '0) ? ZS_IDLE : ZS_STEP;
      default:  state_d = ZS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ZS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ZS_CHECK) && (b_q == '0);
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ZS_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[NW-1];
          mag_q <= num_i[NW-1] ? MW'(-num_i) : MW'(num_i);
          dv_q  <= dev_i;
        end
      end
      ZS_PREP: begin
        t_q  <= EW'(mag_sq) <<< 26;
        p_q  <= dv_ext;
        r_q  <= -dv_ext;
        lo_q <= '0;
        b_q  <= BIT_W'(Z_W - 1);
      end
      ZS_STEP: begin
        pc_q <= p_q + (r_q <<< ({1'b0, b_q} + 5'd2))
                    + (dv_ext <<< ({1'b0, b_q, 1'b0} + 6'd2));
        rc_q <= r_q + (dv_ext <<< ({1'b0, b_q} + 5'd1));
      end
      ZS_CHECK: begin
        if (fits) begin
          p_q <= pc_q;
          r_q <= rc_q;
        end
        lo_q <= lo_n;
        b_q  <= b_q - BIT_W'(1);
        if (b_q == '0) z_q <= z_n;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

[design/zsn_back.sv]
// back end: sample memory, running sums, deviation pass and emit sequencer
// depends on zsn_pkg and zsn_zdiv
module zsn_back #(
  parameter int MAX_SAMPLES = 64,
  parameter int ACTIVE_DIMS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  zsn_pkg::zsn_item_t item_i,
  output logic               pop_o,
  output logic               set_done_o,
  output logic               result_valid_o,
  output logic [zsn_pkg::Z_W-1:0] norm_a_o,
  output logic [zsn_pkg::Z_W-1:0] norm_b_o,
  output logic [zsn_pkg::Z_W-1:0] norm_c_o,
  output logic [zsn_pkg::Z_W-1:0] norm_d_o,
  output logic               final_out_o,
  output logic               overflowed_o,
  output logic               flat_dim_o
);
  import zsn_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int SW = 16 + CW;
  localparam int QW = 30 + CW;
  localparam int DW = 30 + 2 * CW;
  localparam int NW = 17 + CW;

  back_state_e state_q, state_d;

  logic [NUM_DIMS-1:0][FEAT_W-1:0] mem_q [MAX_SAMPLES];
  logic [NUM_DIMS-1:0][FEAT_W-1:0] rd_q;

  logic [CW-1:0]        cnt_q, k_q;
  logic signed [SW-1:0] sum_q [NUM_DIMS];
  logic [QW-1:0]        sq_q  [NUM_DIMS];
  logic [DW-1:0]        dev_q [NUM_DIMS];
  logic                 drop_q, flat_q;
  logic [DIM_W-1:0]     d_q, e_q;
  logic [DW-1:0]        acc_q, mcand_q;
  logic [CW-1:0]        mplier_q;
  logic [Z_W-1:0]       res_q [NUM_DIMS];
  logic [Z_W-1:0]       out_q [NUM_DIMS];
  logic                 ovalid_q, ofinal_q, odrop_q, oflat_q;

  logic [31:0]            sqr [NUM_DIMS];
  logic signed [2*SW-1:0] s_sq;
  logic [DW-1:0]          dev_new;
  logic                   last_dim_dev, last_dim_out, is_final, active, z_needed;
  logic signed [NW-1:0]   num;
  logic                   z_start, z_done;
  logic [Z_W-1:0]         z_val;
  logic                   do_pop;

  // squares of the incoming components
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      sqr[d] = 32'($signed(item_i.feat[d]) * $signed(item_i.feat[d]));
    end
  end

  assign s_sq         = sum_q[d_q] * sum_q[d_q];
  assign dev_new      = acc_q - DW'(s_sq);
  assign last_dim_dev = d_q == DIM_W'(ACTIVE_DIMS - 1);
  assign last_dim_out = e_q == DIM_W'(NUM_DIMS - 1);
  assign is_final     = k_q == (cnt_q - CW'(1));
  assign active       = {1'b0, e_q} < (DIM_W+1)'(ACTIVE_DIMS);
  assign z_needed     = active && (dev_q[e_q] != '0);
  assign num = NW'($signed({1'b0, cnt_q}) * $signed(rd_q[e_q])) - NW'(sum_q[e_q]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:    if (valid_i && item_i.last) state_d = ST_DEVINIT;
      ST_DEVINIT: state_d = ST_DEV;
      ST_DEV:     if (mplier_q == '0) state_d = ST_DEVFIN;
      ST_DEVFIN:  state_d = last_dim_dev ? ST_READ : ST_DEVINIT;
      ST_READ:    state_d = ST_NUM;
      ST_NUM: begin
        if (z_needed)          state_d = ST_ZRUN;
        else if (last_dim_out) state_d = ST_EMIT;
      end
      ST_ZRUN: begin
        if (z_done) state_d = last_dim_out ? ST_EMIT : ST_NUM;
      end
      ST_EMIT:    state_d = is_final ? ST_LOAD : ST_READ;
      default:    state_d = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o      = (state_q == ST_LOAD) && valid_i;
    z_start    = (state_q == ST_NUM) && z_needed;
    set_done_o = (state_q == ST_EMIT) && is_final;
  end
  assign do_pop = pop_o;

  // sample memory, written in load order, read once per emitted sample
  always_ff @(posedge clk_i) begin
    if (do_pop && item_i.keep) begin
      mem_q[cnt_q[AW-1:0]] <= item_i.feat;
    end
    if (state_q == ST_READ) begin
      rd_q <= mem_q[k_q[AW-1:0]];
    end
  end

  // set statistics and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      k_q      <= '0;
      drop_q   <= 1'b0;
      flat_q   <= 1'b0;
      d_q      <= '0;
      e_q      <= '0;
      ovalid_q <= 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
        sum_q[d] <= '0;
        sq_q[d]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (do_pop) begin
            if (item_i.keep) begin
              cnt_q <= cnt_q + CW'(1);
              for (int d = 0; d < NUM_DIMS; d++) begin
                if (d < ACTIVE_DIMS) begin
                  sum_q[d] <= sum_q[d] + SW'($signed(item_i.feat[d]));
                  sq_q[d]  <= sq_q[d] + QW'(sqr[d]);
                end
              end
            end else begin
              drop_q <= 1'b1;
            end
            d_q <= '0;
          end
        end
        ST_DEVFIN: begin
          if (dev_new == '0) flat_q <= 1'b1;
          d_q <= d_q + DIM_W'(1);
          k_q <= '0;
          e_q <= '0;
        end
        ST_NUM: begin
          if (!z_needed) e_q <= e_q + DIM_W'(1);
        end
        ST_ZRUN: begin
          if (z_done) e_q <= e_q + DIM_W'(1);
        end
        ST_EMIT: begin
          ovalid_q <= 1'b1;
          e_q      <= '0;
          if (is_final) begin
            cnt_q  <= '0;
            drop_q <= 1'b0;
            flat_q <= 1'b0;
            for (int d = 0; d < NUM_DIMS; d++) begin
              sum_q[d] <= '0;
              sq_q[d]  <= '0;
            end
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // shift-add product n * sum of squares, then the deviation per dimension
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DEVINIT: begin
        acc_q    <= '0;
        mcand_q  <= DW'(sq_q[d_q]);
        mplier_q <= cnt_q;
      end
      ST_DEV: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      ST_DEVFIN: dev_q[d_q] <= dev_new;
      ST_NUM:    if (!z_needed) res_q[e_q] <= '0;
      ST_ZRUN:   if (z_done) res_q[e_q] <= z_val;
      ST_EMIT: begin
        for (int d = 0; d < NUM_DIMS; d++) out_q[d] <= res_q[d];
        ofinal_q <= is_final;
        odrop_q  <= drop_q;
        oflat_q  <= flat_q;
      end
      default: ;
    endcase
  end

  zsn_zdiv #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_zdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(z_start),
    .num_i  (num),
    .dev_i  (dev_q[e_q]),
    .done_o (z_done),
    .z_o    (z_val)
  );

  assign result_valid_o = ovalid_q;
  assign norm_a_o       = out_q[0];
  assign norm_b_o       = out_q[1];
  assign norm_c_o       = out_q[2];
  assign norm_d_o       = out_q[3];
  assign final_out_o    = ofinal_q;
  assign overflowed_o   = odrop_q;
  assign flat_dim_o     = oflat_q;

endmodule

[design/feature_zscore_normalizer_top.sv]
// top level of the feature z-score normalizer
// depends on zsn_pkg, zsn_front, zsn_fifo, zsn_back
//
// Samples load one per cycle: start_i is taken whenever busy_o is low, and a
// sample arriving with MAX_SAMPLES already stored is dropped and flagged. The
// sample with is_last_i raises busy_o until the whole set has been emitted.
// The deviation pass then runs a shift-add multiplier per dimension, and each
// stored sample is handled dimension by dimension by the bit-serial z-score
// unit (16 search steps plus setup and handoff per dimension; flat or unused
// dimensions give zero without the unit). Each result appears for one cycle
// with result_valid_o; the receiver cannot stall it. busy_o drops in the
// cycle of the final result of a set.
module feature_zscore_normalizer_top #(
  parameter int MAX_SAMPLES = 64,
  parameter int ACTIVE_DIMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] feat_a_i,
  input  logic [15:0] feat_b_i,
  input  logic [15:0] feat_c_i,
  input  logic [15:0] feat_d_i,
  input  logic        is_last_i,
  output logic        result_valid_o,
  output logic [15:0] norm_a_o,
  output logic [15:0] norm_b_o,
  output logic [15:0] norm_c_o,
  output logic [15:0] norm_d_o,
  output logic        final_out_o,
  output logic        overflowed_o,
  output logic        flat_dim_o
);
  import zsn_pkg::*;

  logic [NUM_DIMS-1:0][FEAT_W-1:0] feat;
  zsn_item_t push_item, head_item;
  logic      push, pop, q_valid, q_full, set_done;

  assign feat = {feat_d_i, feat_c_i, feat_b_i, feat_a_i};

  zsn_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .feat_i     (feat),
    .is_last_i  (is_last_i),
    .fifo_full_i(q_full),
    .set_done_i (set_done),
    .push_o     (push),
    .item_o     (push_item)
  );

  zsn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .item_o (head_item)
  );

  zsn_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .ACTIVE_DIMS(ACTIVE_DIMS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .set_done_o    (set_done),
    .result_valid_o(result_valid_o),
    .norm_a_o      (norm_a_o),
    .norm_b_o      (norm_b_o),
    .norm_c_o      (norm_c_o),
    .norm_d_o      (norm_d_o),
    .final_out_o   (final_out_o),
    .overflowed_o  (overflowed_o),
    .flat_dim_o    (flat_dim_o)
  );

endmodule

[design/zsn_checker.sv]
// port-level checks of the feature z-score normalizer, bound to the top level
// depends on feature_zscore_normalizer_top
module zsn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic is_last_i,
  input logic result_valid_o,
  input logic final_out_o
);

  // non-final results only come out while a set is locked in
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !final_out_o) |-> busy_o)
    else $error("result transfer while not busy");

  // results are separated by the per-sample work
  a_emit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result transfers");

  // the input is free again while the last result of a set is out
  a_final_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && final_out_o) |-> !busy_o)
    else $error("still busy at final result");

  // a last sample locks the input
  a_last_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && is_last_i) |=> busy_o)
    else $error("not busy after last sample");

endmodule

bind feature_zscore_normalizer_top zsn_checker u_zsn_checker (.*);
